// ===== rtl/core/ira_pkg.sv =====
package ira_pkg;

	localparam int PIX_W  = 24;
	localparam int ADDR_W = 24;
	localparam int SIZE_W = 13;
	localparam int IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROTATION_MODE = 2'd2;

	typedef enum logic [1:0] {
		MODE_COPY   = 2'd0,
		MODE_ROT90  = 2'd1,
		MODE_ROT180 = 2'd2,
		MODE_ROT270 = 2'd3
	} ira_mode_t;

	// one classified request: dest_address = mul_a * mul_b + add_c (mod 2^24)
	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] mul_a;
		logic [ADDR_W-1:0] mul_b;
		logic [ADDR_W-1:0] add_c;
		logic              last;
	} ira_op_t;

endpackage

// ===== rtl/core/ira_front.sv =====
module ira_front
	import ira_pkg::*;
#(
	parameter int MAX_SIDE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic [SIZE_W-1:0] image_width,
	input  logic [SIZE_W-1:0] image_height,
	input  ira_mode_t         rotation_mode,
	output ira_op_t           op
);

	localparam int CW  = $clog2(MAX_SIDE);
	localparam int SDW = CW + 1;

	logic [CW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [SDW-1:0]    w_eff;
	logic [SDW-1:0]    h_eff;
	logic              last_col;
	logic              last_row;
	logic [ADDR_W-1:0] i24;
	logic [ADDR_W-1:0] j24;
	logic [ADDR_W-1:0] w24;
	logic [ADDR_W-1:0] h24;
	logic [ADDR_W-1:0] h_rem;
	logic [ADDR_W-1:0] w_rem;

	function automatic logic [SDW-1:0] clamp_side(input logic [SIZE_W-1:0] v);
		logic [SDW-1:0] r;
		if (v == '0) begin
			r = SDW'(1);
		end else if (32'(v) > 32'(MAX_SIDE)) begin
			r = SDW'(MAX_SIDE);
		end else begin
			r = SDW'(v);
		end
		return r;
	endfunction

	assign w_eff = clamp_side(image_width);
	assign h_eff = clamp_side(image_height);

	assign last_col = SDW'(col_q) >= (w_eff - SDW'(1));
	assign last_row = SDW'(row_q) >= (h_eff - SDW'(1));

	assign i24   = ADDR_W'(row_q);
	assign j24   = ADDR_W'(col_q);
	assign w24   = ADDR_W'(w_eff);
	assign h24   = ADDR_W'(h_eff);
	assign h_rem = h24 - ADDR_W'(1) - i24;
	assign w_rem = w24 - ADDR_W'(1) - j24;

	// 180 degrees: W*H-1-i*W-j rewritten as (H-1-i)*W + (W-1-j)
	always_comb begin
		op.pixel = pixel_in;
		op.last  = last_col && last_row;
		unique case (rotation_mode)
			MODE_COPY: begin
				op.mul_a = i24;
				op.mul_b = w24;
				op.add_c = j24;
			end
			MODE_ROT90: begin
				op.mul_a = j24;
				op.mul_b = h24;
				op.add_c = h_rem;
			end
			MODE_ROT180: begin
				op.mul_a = h_rem;
				op.mul_b = w24;
				op.add_c = w_rem;
			end
			MODE_ROT270: begin
				op.mul_a = w_rem;
				op.mul_b = h24;
				op.add_c = i24;
			end
			default: begin
				op.mul_a = i24;
				op.mul_b = w24;
				op.add_c = j24;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op.last |=> row_q == '0 && col_q == '0)
		else $error("counters did not wrap after frame end");

endmodule

// ===== rtl/core/ira_queue.sv =====
module ira_queue
	import ira_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  ira_op_t wr_data,
	output logic    full,
	input  logic    rd,
	output ira_op_t rd_data,
	output logic    empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	ira_op_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full    = count_q == NW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + NW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !empty)
		else $error("queue read while empty");

endmodule

// ===== rtl/core/ira_back.sv =====
module ira_back
	import ira_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ira_op_t           q_data,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [ADDR_W-1:0] dest_address,
	output logic              frame_end
);

	logic              v_s1;
	logic [ADDR_W-1:0] prod_s1;
	logic [ADDR_W-1:0] add_c_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic              last_s1;
	logic              v_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [PIX_W-1:0]  pixel_s2;
	logic              last_s2;
	logic              out_take;
	logic              adv2;
	logic              adv1;

	assign out_take = pop && v_s2;
	assign adv2     = v_s1 && (!v_s2 || out_take);
	assign adv1     = !q_empty && (!v_s1 || adv2);
	assign q_pop    = adv1;

	// stage 1: multiply, low 24 bits kept
	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s1  <= ADDR_W'(q_data.mul_a * q_data.mul_b);
			add_c_s1 <= q_data.add_c;
			pixel_s1 <= q_data.pixel;
			last_s1  <= q_data.last;
		end
	end

	// stage 2: add, output register
	always_ff @(posedge clk) begin
		if (adv2) begin
			addr_s2  <= prod_s1 + add_c_s1;
			pixel_s2 <= pixel_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= 1'b1;
			end else if (adv2) begin
				v_s1 <= 1'b0;
			end
			if (adv2) begin
				v_s2 <= 1'b1;
			end else if (out_take) begin
				v_s2 <= 1'b0;
			end
		end
	end

	assign empty        = !v_s2;
	assign pixel_out    = pixel_s2;
	assign dest_address = addr_s2;
	assign frame_end    = last_s2;

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1)
		else $error("stage 1 request dropped");

endmodule

// ===== rtl/core/image_rotate_address_generator.sv =====
// Channel   | Handshake                    | Payload
// ----------+------------------------------+--------------------------------------
// input     | push / full                  | pixel_in[23:0]
// result    | pop / empty                  | pixel_out, dest_address, frame_end
// config    | cfg_valid / cfg_ready (=1)   | cfg_index[1:0], cfg_data[12:0]
//
// One pixel per clock sustained while the result side pops every clock; each request yields one result.
// A request is written into the queue on the accepting edge, then passes the multiply stage and
// then the add stage, whose output register drives the result ports.
// Reset clears the row/column counters, queue and valid flags; width/height reset to 1, mode to 0.
// A stalled result side fills the output pipeline and then the request queue; full rises only
// when the queue holds QUEUE_DEPTH requests, so the input side keeps going through short stalls.
module image_rotate_address_generator
	import ira_pkg::*;
#(
	parameter int MAX_SIDE    = 4096,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// input side
	input  logic              push,
	output logic              full,
	input  logic [PIX_W-1:0]  pixel_in,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [ADDR_W-1:0] dest_address,
	output logic              frame_end,
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;
	ira_mode_t         rotation_mode_q;
	logic              accept;
	logic              cfg_wr;
	ira_op_t           front_op;
	ira_op_t           q_data;
	logic              q_empty;
	logic              q_pop;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = push && !full;

	// register file; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= SIZE_W'(1);
			image_height_q  <= SIZE_W'(1);
			rotation_mode_q <= MODE_COPY;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				REG_ROTATION_MODE: rotation_mode_q <= ira_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// front: raster counters, clamp, per-mode operand selection
	ira_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.pixel_in      (pixel_in),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.rotation_mode (rotation_mode_q),
		.op            (front_op)
	);

	// decouples counter front from the multiply/add back end
	ira_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (accept),
		.wr_data (front_op),
		.full    (full),
		.rd      (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// back: multiply, add, output register
	ira_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.pixel_out    (pixel_out),
		.dest_address (dest_address),
		.frame_end    (frame_end)
	);

endmodule

// ===== dv/rotate_placement_checker.sv =====
`timescale 1ns / 1ps

module rotate_placement_checker
	import ira_pkg::*;
#(
	parameter int MAX_SIDE = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic              empty,
	input  logic              pop,
	input  logic [PIX_W-1:0]  pixel_out,
	input  logic [ADDR_W-1:0] dest_address,
	input  logic              frame_end,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} placement_t;

	placement_t        placement_q[$];
	placement_t        oldest;
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	ira_mode_t         mode_reg;
	logic [11:0]       row;
	logic [11:0]       col;

	function automatic logic [SIZE_W-1:0] legal_side(input logic [SIZE_W-1:0] v);
		if (v == '0)
			return SIZE_W'(1);
		if (v > MAX_SIDE)
			return SIZE_W'(MAX_SIDE);
		return v;
	endfunction

	// destination of the pixel at (row, col); advances the raster position
	function automatic placement_t place_pixel(input logic [PIX_W-1:0] px);
		logic [63:0] w;
		logic [63:0] h;
		logic [63:0] i;
		logic [63:0] j;
		logic [63:0] a;
		placement_t  p;
		w = 64'(legal_side(width_reg));
		h = 64'(legal_side(height_reg));
		i = 64'(row);
		j = 64'(col);
		case (mode_reg)
			MODE_ROT90:  a = j * h + (h - 1 - i);
			MODE_ROT180: a = w * h - 1 - i * w - j;
			MODE_ROT270: a = (w - 1 - j) * h + i;
			default:     a = i * w + j;
		endcase
		p.pixel = px;
		p.addr  = a[ADDR_W-1:0];
		p.last  = 1'b0;
		// counters past a shrunken size wrap on the next pixel
		if (j >= w - 1) begin
			col = '0;
			if (i >= h - 1) begin
				row    = '0;
				p.last = 1'b1;
			end else begin
				row = row + 1'b1;
			end
		end else begin
			col = col + 1'b1;
		end
		return p;
	endfunction

	task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
		errors++;
		$display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			width_reg  = SIZE_W'(1);
			height_reg = SIZE_W'(1);
			mode_reg   = MODE_COPY;
			row        = '0;
			col        = '0;
			errors     = 0;
			placement_q.delete();
		end else begin
			if (push && !full)
				placement_q.push_back(place_pixel(pixel_in));
			if (pop && !empty) begin
				if (placement_q.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: pixel %h addr %h end %b",
						$time, pixel_out, dest_address, frame_end);
				end else begin
					oldest = placement_q.pop_front();
					if (pixel_out !== oldest.pixel)
						report("pixel_out", 32'(oldest.pixel), 32'(pixel_out));
					if (dest_address !== oldest.addr)
						report("dest_address", 32'(oldest.addr), 32'(dest_address));
					if (frame_end !== oldest.last)
						report("frame_end", 32'(oldest.last), 32'(frame_end));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:   width_reg  = cfg_data;
					REG_IMAGE_HEIGHT:  height_reg = cfg_data;
					REG_ROTATION_MODE: mode_reg   = ira_mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
		end
		pending = placement_q.size();
	end

endmodule

// ===== dv/image_rotate_address_generator_tb.sv =====
`timescale 1ns / 1ps

module image_rotate_address_generator_tb;
	import ira_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STAGE_PIXELS = 185;   // three idle profiles, at least 555 pixels in all
	localparam int PIPE_CYCLES = 3;      // settling cycles after the last result
	localparam int MAX_SIDE_TB = 4096;
	// index past the last register; writes there must leave everything alone
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [PIX_W-1:0]  pixel_in = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [PIX_W-1:0]  pixel_out;
	logic [ADDR_W-1:0] dest_address;
	logic              frame_end;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	int tx_idle_pct = 20;
	int rx_idle_pct = 78;

	always #2 clk = ~clk;

	image_rotate_address_generator u_top (.*);

	rotate_placement_checker u_check (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("image_rotate_address_generator: mismatch");
			$finish;
		end
	end

	// result side: random backpressure per the current profile
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle_pct);
	end

	// push stays high after the accept; the next request or an idle gap decides
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		pixel_in <= px;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// stop sending, wait for every expected result, then let the pipe settle
	task automatic drain_results();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	// cfg_valid is left high; the caller lowers it after the last write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input logic [SIZE_W-1:0] mode_data);
		drain_results();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_ROTATION_MODE, mode_data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] random_pixel();
		if ($urandom_range(15) == 0)
			return $urandom_range(1) ? {PIX_W{1'b1}} : '0;
		return PIX_W'($urandom());
	endfunction

	// one random setting followed by a burst of pixels, mostly whole frames
	task automatic random_frame_run();
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [SIZE_W-1:0] mode_data;
		int                pick;
		int                n;
		pick = $urandom_range(9);
		if (pick == 0) begin
			// out-of-range and huge sizes: only a few pixels, so only the smallest frames can close
			case ($urandom_range(3))
				0:       w = '0;
				1:       w = SIZE_W'(MAX_SIDE_TB);
				2:       w = SIZE_W'($urandom_range(MAX_SIDE_TB + 1, 8191));
				default: w = SIZE_W'($urandom_range(100, MAX_SIDE_TB - 1));
			endcase
			h = $urandom_range(1) ? SIZE_W'($urandom_range(8191)) : SIZE_W'($urandom_range(1, 4));
			n = $urandom_range(1, 12);
		end else begin
			w = SIZE_W'($urandom_range(1, 8));
			h = SIZE_W'($urandom_range(1, 6));
			n = (pick < 8) ? int'(w * h * $urandom_range(1, 3)) : int'($urandom_range(1, 20));
		end
		// junk in the upper mode bits is dropped by the block
		mode_data = {($urandom_range(3) == 0) ? 11'($urandom()) : 11'd0,
			2'($urandom_range(3))};

		drain_results();
		if ($urandom_range(4) == 0)
			write_reg(REG_SPARE, SIZE_W'($urandom()));
		// now and then keep the old size so the counters carry across
		if ($urandom_range(7) != 0) begin
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
		end
		write_reg(REG_ROTATION_MODE, mode_data);
		cfg_valid <= 1'b0;
		@(posedge clk);

		repeat (n) begin
			if ($urandom_range(39) == 0)
				drain_results();
			send_pixel(random_pixel());
		end
		sent += n;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 1x1: every pixel closes a frame
		send_pixel('0);
		send_pixel({PIX_W{1'b1}});

		// width 0 reads as 1, height past the max reads as the max
		configure('0, 13'h1FFF, SIZE_W'(MODE_ROT90));
		send_pixel(24'hAAAAAA);
		send_pixel(24'h555555);
		send_pixel(24'h000001);

		// 3x2 at 180, stop one pixel into the second row
		configure(13'd3, 13'd2, SIZE_W'(MODE_ROT180));
		repeat (4) send_pixel(random_pixel());

		// shrink mid-frame: counters past the size, address wraps below zero
		configure(13'd1, 13'd1, SIZE_W'(MODE_ROT180));
		send_pixel(24'h800000);
		send_pixel(24'h7FFFFF);

		// largest frame, both directions that use the full side
		configure(13'd4096, 13'd4096, SIZE_W'(MODE_ROT180));
		send_pixel(random_pixel());
		send_pixel(random_pixel());
		configure(13'd4096, 13'd4096, SIZE_W'(MODE_ROT270));
		send_pixel(random_pixel());
		send_pixel(random_pixel());

		// spare index ignored, mode with junk upper bits, then a clean 2x2 copy
		drain_results();
		write_reg(REG_SPARE, 13'h1FFF);
		cfg_valid <= 1'b0;
		@(posedge clk);
		configure(13'd2, 13'd2, {11'h7FF, 2'(MODE_COPY)});
		repeat (4) send_pixel(random_pixel());

		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					tx_idle_pct = 20;
					rx_idle_pct = 78;
				end
				1: begin
					tx_idle_pct = 78;
					rx_idle_pct = 20;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			while (sent < (stage + 1) * STAGE_PIXELS)
				random_frame_run();
		end

		drain_results();
		repeat (2 * PIPE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("image_rotate_address_generator: match");
		else
			$display("image_rotate_address_generator: mismatch");
		$finish;
	end

endmodule
